### rtl/blps_pkg.sv
`timescale 1ns / 1ps
package blps_pkg;

   // coordinate width of the endpoints by default
   localparam int COORD_BITS_DEF = 16;

   localparam int PIX_W      = 17;  // screen coordinate width
   localparam int ORIGIN_W   = 16;
   localparam int VIEW_W     = 14;
   localparam int PITCH_W    = 16;
   localparam int WORD_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int BYTE_SHIFT = 2;   // four bytes a pixel

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OFFSET_X,
      REG_OFFSET_Y,
      REG_VIEW_WIDTH,
      REG_VIEW_HEIGHT,
      REG_ROW_PITCH,
      REG_STROKE_COLOR,
      REG_BASE_ADDRESS
   } csr_idx_type;

   typedef struct packed {
      logic signed [ORIGIN_W-1:0] offset_x;
      logic signed [ORIGIN_W-1:0] offset_y;
      logic [VIEW_W-1:0]          view_width;
      logic [VIEW_W-1:0]          view_height;
      logic [PITCH_W-1:0]         row_pitch;
      logic [WORD_W-1:0]          stroke_color;
      logic [WORD_W-1:0]          base_address;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      offset_x:     16'sd0,
      offset_y:     16'sd0,
      view_width:   14'd1024,
      view_height:  14'd768,
      row_pitch:    16'd4096,
      stroke_color: 32'h00FF_FFFF,
      base_address: 32'h0000_0000
   };

   // flags travelling with a stepped pixel
   typedef struct packed {
      logic last;
      logic blank;   // step with no line active
   } step_flags_type;

   // clipped pixel on its way to address generation
   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
      logic                    drawn;
      logic                    last;
      logic [VIEW_W-1:0]       col;
      logic [VIEW_W-1:0]       row;
   } clip_type;

endpackage

### rtl/blps_csr.sv
`timescale 1ns / 1ps
module blps_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [blps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blps_pkg::CSR_DATA_W-1:0] csr_data,
   output blps_pkg::cfg_type               cfg
);
   import blps_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_OFFSET_X:     cfg_in.offset_x     = csr_data[ORIGIN_W-1:0];
            REG_OFFSET_Y:     cfg_in.offset_y     = csr_data[ORIGIN_W-1:0];
            REG_VIEW_WIDTH:   cfg_in.view_width   = csr_data[VIEW_W-1:0];
            REG_VIEW_HEIGHT:  cfg_in.view_height  = csr_data[VIEW_W-1:0];
            REG_ROW_PITCH:    cfg_in.row_pitch    = csr_data[PITCH_W-1:0];
            REG_STROKE_COLOR: cfg_in.stroke_color = csr_data[WORD_W-1:0];
            REG_BASE_ADDRESS: cfg_in.base_address = csr_data[WORD_W-1:0];
            default:          cfg_in = cfg_ff;  // unused index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/blps_step.sv
`timescale 1ns / 1ps
module blps_step #(
   parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         mode,
   input  logic signed [COORD_BITS-1:0] x_start,
   input  logic signed [COORD_BITS-1:0] y_start,
   input  logic signed [COORD_BITS-1:0] x_end,
   input  logic signed [COORD_BITS-1:0] y_end,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output blps_pkg::step_flags_type     out_flags
);
   import blps_pkg::*;

   localparam int SPAN_W  = COORD_BITS + 1;
   localparam int NSPAN_W = COORD_BITS + 2;
   localparam int ERR_W   = COORD_BITS + 3;

   // line state; cur_x/cur_y double as the pixel register
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [SPAN_W-1:0]     span_x_ff, span_x_in;
   logic signed [NSPAN_W-1:0]    nspan_y_ff, nspan_y_in;
   logic                         dir_xn_ff, dir_xn_in, dir_yn_ff, dir_yn_in;
   logic                         active_ff, active_in;
   logic                         vld_ff, vld_in;
   step_flags_type               flags_ff, flags_in;

   logic                         accept;
   logic signed [SPAN_W-1:0]     dx, dy, abs_dx;
   logic signed [NSPAN_W-1:0]    neg_abs_dy;
   logic signed [ERR_W:0]        e2;
   logic                         go_x, go_y;
   logic signed [COORD_BITS-1:0] nx, ny;

   assign in_ready  = !vld_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = vld_ff;
   assign out_x     = cur_x_ff;
   assign out_y     = cur_y_ff;
   assign out_flags = flags_ff;

   // start set-up
   always_comb begin
      dx         = SPAN_W'(x_end) - SPAN_W'(x_start);
      dy         = SPAN_W'(y_end) - SPAN_W'(y_start);
      abs_dx     = dx[SPAN_W-1] ? -dx : dx;
      neg_abs_dy = dy[SPAN_W-1] ? NSPAN_W'(dy) : -NSPAN_W'(dy);
   end

   // one Bresenham step from the current state
   always_comb begin
      e2   = {err_ff, 1'b0};
      go_x = e2 >= (ERR_W + 1)'(nspan_y_ff);
      go_y = e2 <= (ERR_W + 1)'(span_x_ff);
      nx   = cur_x_ff;
      ny   = cur_y_ff;
      if (go_x) begin
         nx = dir_xn_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
      end
      if (go_y) begin
         ny = dir_yn_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
      end
   end

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      tgt_x_in   = tgt_x_ff;
      tgt_y_in   = tgt_y_ff;
      err_in     = err_ff;
      span_x_in  = span_x_ff;
      nspan_y_in = nspan_y_ff;
      dir_xn_in  = dir_xn_ff;
      dir_yn_in  = dir_yn_ff;
      active_in  = active_ff;
      flags_in   = flags_ff;
      vld_in     = in_ready ? in_valid : vld_ff;
      if (accept) begin
         priority if (mode == MODE_START) begin
            cur_x_in       = x_start;
            cur_y_in       = y_start;
            tgt_x_in       = x_end;
            tgt_y_in       = y_end;
            span_x_in      = abs_dx;
            nspan_y_in     = neg_abs_dy;
            dir_xn_in      = x_start >= x_end;
            dir_yn_in      = y_start >= y_end;
            err_in         = ERR_W'(abs_dx) + ERR_W'(neg_abs_dy);
            flags_in.last  = (x_start == x_end) && (y_start == y_end);
            flags_in.blank = 1'b0;
            active_in      = !flags_in.last;
         end else if (active_ff) begin
            cur_x_in       = nx;
            cur_y_in       = ny;
            err_in         = err_ff + (go_x ? ERR_W'(nspan_y_ff) : ERR_W'(0))
                                    + (go_y ? ERR_W'(span_x_ff) : ERR_W'(0));
            flags_in.last  = (nx == tgt_x_ff) && (ny == tgt_y_ff);
            flags_in.blank = 1'b0;
            active_in      = !flags_in.last;
         end else begin
            // no line: state holds, result is blanked downstream
            flags_in.last  = 1'b1;
            flags_in.blank = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         tgt_x_ff   <= '0;
         tgt_y_ff   <= '0;
         err_ff     <= '0;
         span_x_ff  <= '0;
         nspan_y_ff <= '0;
         dir_xn_ff  <= 1'b0;
         dir_yn_ff  <= 1'b0;
         active_ff  <= 1'b0;
         vld_ff     <= 1'b0;
         flags_ff   <= '0;
      end else begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         tgt_x_ff   <= tgt_x_in;
         tgt_y_ff   <= tgt_y_in;
         err_ff     <= err_in;
         span_x_ff  <= span_x_in;
         nspan_y_ff <= nspan_y_in;
         dir_xn_ff  <= dir_xn_in;
         dir_yn_ff  <= dir_yn_in;
         active_ff  <= active_in;
         vld_ff     <= vld_in;
         flags_ff   <= flags_in;
      end
   end

   // a finished line leaves nothing active behind it
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      vld_ff && flags_ff.last && !flags_ff.blank |-> !active_ff)
      else $error("line still active after its last pixel");

   // a step with no line must not disturb the state
   a_idle_step_holds: assert property (@(posedge clock) disable iff (reset)
      accept && (mode == MODE_STEP) && !active_ff
      |=> $stable(cur_x_ff) && $stable(cur_y_ff) && $stable(err_ff))
      else $error("idle step changed line state");

endmodule

### rtl/blps_clip.sv
`timescale 1ns / 1ps
module blps_clip #(
   parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  blps_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  blps_pkg::step_flags_type     in_flags,
   output logic                         out_valid,
   input  logic                         out_ready,
   output blps_pkg::clip_type           out_pix
);
   import blps_pkg::*;

   localparam int SUM_W = ((COORD_BITS > ORIGIN_W) ? COORD_BITS : ORIGIN_W) + 1;

   logic               vld_ff, vld_in;
   clip_type           pix_ff, pix_in;
   logic signed [SUM_W-1:0] sx, sy, lim_x, lim_y;
   logic               in_view;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_pix   = pix_ff;

   always_comb begin
      sx      = SUM_W'(in_x) + SUM_W'(cfg.offset_x);
      sy      = SUM_W'(in_y) + SUM_W'(cfg.offset_y);
      lim_x   = SUM_W'($signed({1'b0, cfg.view_width}));
      lim_y   = SUM_W'($signed({1'b0, cfg.view_height}));
      in_view = !sx[SUM_W-1] && (sx < lim_x) && !sy[SUM_W-1] && (sy < lim_y);

      pix_in         = pix_ff;
      vld_in         = in_ready ? in_valid : vld_ff;
      if (in_ready) begin
         pix_in.pixel_x = in_flags.blank ? '0 : sx[PIX_W-1:0];
         pix_in.pixel_y = in_flags.blank ? '0 : sy[PIX_W-1:0];
         pix_in.drawn   = !in_flags.blank && in_view;
         pix_in.last    = in_flags.last;
         pix_in.col     = sx[VIEW_W-1:0];
         pix_in.row     = sy[VIEW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   // a drawn pixel lies on screen
   a_drawn_on_screen: assert property (@(posedge clock) disable iff (reset)
      vld_ff && pix_ff.drawn
      |-> !pix_ff.pixel_x[PIX_W-1] && !pix_ff.pixel_y[PIX_W-1])
      else $error("drawn pixel off screen");

endmodule

### rtl/blps_addr.sv
`timescale 1ns / 1ps
module blps_addr (
   input  logic                        clock,
   input  logic                        reset,
   input  blps_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  blps_pkg::clip_type          in_pix,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [blps_pkg::PIX_W-1:0] pixel_x,
   output logic signed [blps_pkg::PIX_W-1:0] pixel_y,
   output logic                        drawn,
   output logic [blps_pkg::WORD_W-1:0] address,
   output logic                        last
);
   import blps_pkg::*;

   localparam int PROD_W = VIEW_W + PITCH_W;

   logic                    vld_ff, vld_in;
   logic signed [PIX_W-1:0] px_ff, px_in, py_ff, py_in;
   logic                    drawn_ff, drawn_in, last_ff, last_in;
   logic [WORD_W-1:0]       addr_ff, addr_in;
   logic [PROD_W-1:0]       row_off;
   logic [WORD_W-1:0]       sum;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign pixel_x   = px_ff;
   assign pixel_y   = py_ff;
   assign drawn     = drawn_ff;
   assign address   = addr_ff;
   assign last      = last_ff;

   always_comb begin
      row_off  = PROD_W'(in_pix.row) * PROD_W'(cfg.row_pitch);
      sum      = cfg.base_address + WORD_W'(row_off)
               + (WORD_W'(in_pix.col) << BYTE_SHIFT);
      vld_in   = in_ready ? in_valid : vld_ff;
      px_in    = in_ready ? in_pix.pixel_x : px_ff;
      py_in    = in_ready ? in_pix.pixel_y : py_ff;
      drawn_in = in_ready ? in_pix.drawn : drawn_ff;
      last_in  = in_ready ? in_pix.last : last_ff;
      addr_in  = addr_ff;
      if (in_ready) begin
         addr_in = in_pix.drawn ? sum : '0;   // clipped pixels give zero
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      drawn_ff <= drawn_in;
      last_ff  <= last_in;
      addr_ff  <= addr_in;
   end

   a_clipped_zero_addr: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !drawn_ff |-> addr_ff == '0)
      else $error("clipped pixel carries an address");

endmodule

### rtl/bresenham_line_pixel_stepper.sv
`timescale 1ns / 1ps
// Bresenham line stepper, all octants, with clipping and address output.
// Request channel (req_*): req_mode = start loads both endpoints and gives
// the first pixel; req_mode = step advances one pixel. One item in gives
// exactly one item out on the response channel (rsp_*).
// Each response carries the screen coordinate (line point plus origin),
// drawn (inside the view and a line active), the byte address
// base + y*pitch + x*4 (zero when clipped), the stroke colour and last.
// A step with no line active gives a blank pixel with last set.
// Pipe: stepper, clip and address registers, in that order. Throughput:
// one item a cycle while the receiver does not stall, set by the
// error-term update loop. Receiver stall: each stage holds its item;
// ready goes low back up the pipe only when every stage is full, so
// up to three items sit in flight.
// Configuration (csr_*): always ready; write only while no item is in
// flight. Reset: synchronous, clears the pipe, drops any active line and
// reloads the register defaults.
module bresenham_line_pixel_stepper #(
   parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [blps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blps_pkg::CSR_DATA_W-1:0] csr_data,
   // request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic signed [COORD_BITS-1:0]    req_x_start,
   input  logic signed [COORD_BITS-1:0]    req_y_start,
   input  logic signed [COORD_BITS-1:0]    req_x_end,
   input  logic signed [COORD_BITS-1:0]    req_y_end,
   // response
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [blps_pkg::PIX_W-1:0] rsp_pixel_x,
   output logic signed [blps_pkg::PIX_W-1:0] rsp_pixel_y,
   output logic                            rsp_drawn,
   output logic [blps_pkg::WORD_W-1:0]     rsp_address,
   output logic [blps_pkg::WORD_W-1:0]     rsp_color,
   output logic                            rsp_last
);
   import blps_pkg::*;

   cfg_type                      cfg;
   logic                         st_valid, st_ready;
   logic signed [COORD_BITS-1:0] st_x, st_y;
   step_flags_type               st_flags;
   logic                         cl_valid, cl_ready;
   clip_type                     cl_pix;

   blps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // error-term stepper; its state register is also the first pipe stage
   blps_step #(.COORD_BITS(COORD_BITS)) u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .mode      (req_mode),
      .x_start   (req_x_start),
      .y_start   (req_y_start),
      .x_end     (req_x_end),
      .y_end     (req_y_end),
      .out_valid (st_valid),
      .out_ready (st_ready),
      .out_x     (st_x),
      .out_y     (st_y),
      .out_flags (st_flags)
   );

   // origin offset and view test
   blps_clip #(.COORD_BITS(COORD_BITS)) u_clip (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (st_valid),
      .in_ready  (st_ready),
      .in_x      (st_x),
      .in_y      (st_y),
      .in_flags  (st_flags),
      .out_valid (cl_valid),
      .out_ready (cl_ready),
      .out_pix   (cl_pix)
   );

   // row multiply and byte address; its output register is the response register
   blps_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (cl_valid),
      .in_ready  (cl_ready),
      .in_pix    (cl_pix),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .pixel_x   (rsp_pixel_x),
      .pixel_y   (rsp_pixel_y),
      .drawn     (rsp_drawn),
      .address   (rsp_address),
      .last      (rsp_last)
   );

   // colour comes off the register; the user, unchecked, holds it per line
   assign rsp_color = cfg.stroke_color;

endmodule
